[rtl/core/fwma_pkg.sv]
// Shared constants, command and status types for the FIR / moving average block.
package fwma_pkg;

  // History and coefficient storage (depth must be a power of two)
  localparam int unsigned HIST_DEPTH = 64;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W      = HIST_AW + 1;

  // Field widths
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned HALF_W   = ACC_W / 2;
  localparam int unsigned SUM_W    = 31;
  localparam int unsigned AVG_W    = 24;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DEN_W    = 16;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned IDX_W    = 6;

  // Configuration port
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_AVG_LEN   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_GAIN_NUM  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_GAIN_DEN  = 2'd3;

  // Input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PUSH = 1'b1;

  // Divider step counts
  localparam int unsigned DIV_CNT_W     = 7;
  localparam int unsigned DIV_FIR_STEPS = ACC_W;
  localparam int unsigned DIV_AVG_STEPS = HALF_W;

  // Controller to datapath commands
  typedef struct packed {
    logic               accept;
    logic               coef_wr;
    logic               commit;
    logic               mac_issue;
    logic [HIST_AW-1:0] tap_idx;
    logic               gain_lo;
    logic               gain_hi;
    logic               gain_sum;
    logic               div_fir;
    logic               div_avg;
    logic               fir_latch;
    logic               avg_latch;
    logic               out_load;
  } fwma_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] taps;
    logic             mac_busy;
    logic             div_busy;
    logic             seen_nz;
  } fwma_sts_t;

endpackage

[rtl/core/fwma_ctrl.sv]
// Sequencing state machine for the FIR / moving average block.
module fwma_ctrl
  import fwma_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      command_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  fwma_sts_t sts_i,
  output fwma_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SUM   = 13'b0000000000010,
    S_MAC   = 13'b0000000000100,
    S_DRAIN = 13'b0000000001000,
    S_GLO   = 13'b0000000010000,
    S_GHI   = 13'b0000000100000,
    S_GSUM  = 13'b0000001000000,
    S_FLD   = 13'b0000010000000,
    S_DIVF  = 13'b0000100000000,
    S_FFIN  = 13'b0001000000000,
    S_DIVA  = 13'b0010000000000,
    S_AFIN  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e             state_q, state_d;
  logic [HIST_AW-1:0] k_q, k_d;
  logic               out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (command_i == CMD_LOAD) begin
            cmd_o.coef_wr = 1'b1;
            state_d       = S_OUT;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        cmd_o.commit = 1'b1;
        k_d          = '0;
        state_d      = (sts_i.taps == '0) ? S_DRAIN : S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.tap_idx   = k_q;
        k_d             = k_q + 1'b1;
        if ({1'b0, k_q} == sts_i.taps - 1'b1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.mac_busy) begin
          state_d = S_GLO;
        end
      end
      S_GLO: begin
        cmd_o.gain_lo = 1'b1;
        state_d       = S_GHI;
      end
      S_GHI: begin
        cmd_o.gain_hi = 1'b1;
        state_d       = S_GSUM;
      end
      S_GSUM: begin
        cmd_o.gain_sum = 1'b1;
        state_d        = S_FLD;
      end
      S_FLD: begin
        cmd_o.div_fir = 1'b1;
        state_d       = S_DIVF;
      end
      S_DIVF: begin
        if (!sts_i.div_busy) begin
          state_d = S_FFIN;
        end
      end
      S_FFIN: begin
        cmd_o.fir_latch = 1'b1;
        if (sts_i.seen_nz) begin
          cmd_o.div_avg = 1'b1;
          state_d       = S_DIVA;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIVA: begin
        if (!sts_i.div_busy) begin
          state_d = S_AFIN;
        end
      end
      S_AFIN: begin
        cmd_o.avg_latch = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, tap counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_divf_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVF && !sts_i.div_busy) |=> (state_q == S_FFIN))
    else $error("FIR divide wait did not exit to latch");
  a_drain_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GLO) |-> !sts_i.mac_busy)
    else $error("gain stage entered with MAC pipeline busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("pending result dropped");
`endif

endmodule

[rtl/core/fwma_dp.sv]
// Datapath: config, history and coefficient memories, MAC, gain and shared divider.
module fwma_dp
  import fwma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [IDX_W-1:0]    coef_index_i,
  input  logic [COEF_W-1:0]   coef_value_i,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  input  fwma_cmd_t           cmd_i,
  output fwma_sts_t           sts_o,
  output logic [ACC_W-1:0]    filtered_value_o,
  output logic [AVG_W-1:0]    average_value_o,
  output logic                average_valid_o
);

  // Configuration registers
  logic [LEN_W-1:0]  tap_q, alen_q;
  logic [GAIN_W-1:0] gnum_q;
  logic [DEN_W-1:0]  gden_q;
  logic [CNT_W-1:0]  taps_sat, alen_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= LEN_W'(1);
      alen_q <= '0;
      gnum_q <= GAIN_W'(1);
      gden_q <= DEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAP_COUNT: tap_q  <= cfg_data_i[LEN_W-1:0];
        CFG_AVG_LEN:   alen_q <= cfg_data_i[LEN_W-1:0];
        CFG_GAIN_NUM:  gnum_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_DEN:  gden_q <= cfg_data_i[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign taps_sat = (CNT_W'(tap_q) > CNT_W'(HIST_DEPTH)) ? CNT_W'(HIST_DEPTH) : CNT_W'(tap_q);
  assign alen_sat = (CNT_W'(alen_q) > CNT_W'(HIST_DEPTH)) ? CNT_W'(HIST_DEPTH)
                                                          : CNT_W'(alen_q);

  // Running state
  logic [HIST_AW-1:0]  wp_q, pos_q, wp_next;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    seen_q;
  logic [AVG_W-1:0]    last_avg_q;
  logic [SAMPLE_W-1:0] sample_q;

  // Coefficient memory
  logic [COEF_W-1:0] coef_mem [HIST_DEPTH];
  logic [COEF_W-1:0] coef_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr) begin
      coef_mem[coef_index_i[HIST_AW-1:0]] <= coef_value_i;
    end
    coef_rd_q <= coef_mem[cmd_i.tap_idx];
  end

  // Sample history memory; entries never written read as zero
  logic [SAMPLE_W-1:0]   hist_mem [HIST_DEPTH];
  logic [SAMPLE_W-1:0]   hist_rd_q, hist_rdata;
  logic [HIST_DEPTH-1:0] hist_vld_q;
  logic                  hist_rv_q;
  logic [HIST_AW-1:0]    hist_ra;

  assign hist_ra = cmd_i.accept ? (wp_q - alen_sat[HIST_AW-1:0]) : (pos_q + cmd_i.tap_idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hist_mem[wp_q] <= sample_q;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      hist_rv_q  <= 1'b0;
    end else begin
      hist_rv_q <= hist_vld_q[hist_ra];
      if (cmd_i.commit) begin
        hist_vld_q[wp_q] <= 1'b1;
      end
    end
  end

  assign hist_rdata = hist_rv_q ? hist_rd_q : '0;

  // Sample capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_value_i;
    end
  end

  // Commit: average sum, sample count, write pointer
  logic [SUM_W-1:0] old_ext, new_ext;
  assign old_ext = SUM_W'($signed(hist_rdata));
  assign new_ext = SUM_W'($signed(sample_q));
  assign wp_next = (wp_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      sum_q  <= '0;
      seen_q <= '0;
    end else if (cmd_i.commit) begin
      wp_q <= wp_next;
      if (alen_sat != '0) begin
        sum_q <= sum_q - old_ext + new_ext;
        if (seen_q < alen_sat) begin
          seen_q <= seen_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pos_q <= wp_next - taps_sat[HIST_AW-1:0];
    end
  end

  // MAC pipeline: read, multiply, accumulate
  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(coef_rd_q) * $signed(hist_rdata);
    if (cmd_i.commit) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Gain multiply, split into two halves, modulo 2^64
  logic signed [HALF_W+GAIN_W:0] plo_q;
  logic [HALF_W-1:0]             phi_q;
  logic [ACC_W-1:0]              gain_q;
  logic [HALF_W-1:0]             gnum_ext;

  assign gnum_ext = HALF_W'($signed(gnum_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain_lo) begin
      plo_q <= $signed({1'b0, acc_q[HALF_W-1:0]}) * $signed(gnum_q);
    end
    if (cmd_i.gain_hi) begin
      phi_q <= HALF_W'(acc_q[ACC_W-1:HALF_W] * gnum_ext);
    end
    if (cmd_i.gain_sum) begin
      gain_q <= ACC_W'(plo_q) + {phi_q, {HALF_W{1'b0}}};
    end
  end

  // Shared restoring divider, one quotient bit per cycle
  logic [ACC_W-1:0]     dq_q;
  logic [DEN_W-1:0]     rem_q, dv_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic                 neg_q;
  logic                 div_busy;
  logic [DEN_W:0]       trial;
  logic [SUM_W-1:0]     sum_mag;
  logic [HALF_W-1:0]    avg_q32;

  assign div_busy = (dcnt_q != '0);
  assign trial    = {rem_q, dq_q[ACC_W-1]};
  assign sum_mag  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
  assign avg_q32  = neg_q ? (HALF_W'(0) - dq_q[HALF_W-1:0]) : dq_q[HALF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_fir) begin
      dcnt_q <= DIV_CNT_W'(DIV_FIR_STEPS);
    end else if (cmd_i.div_avg) begin
      dcnt_q <= DIV_CNT_W'(DIV_AVG_STEPS);
    end else if (div_busy) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_fir) begin
      dq_q  <= gain_q[ACC_W-1] ? (ACC_W'(0) - gain_q) : gain_q;
      rem_q <= '0;
      dv_q  <= (gden_q == '0) ? DEN_W'(1) : gden_q;
      neg_q <= gain_q[ACC_W-1];
    end else if (cmd_i.div_avg) begin
      dq_q  <= {1'b0, sum_mag, {HALF_W{1'b0}}};
      rem_q <= '0;
      dv_q  <= DEN_W'(seen_q);
      neg_q <= sum_q[SUM_W-1];
    end else if (div_busy) begin
      if (trial >= {1'b0, dv_q}) begin
        rem_q <= DEN_W'(trial - {1'b0, dv_q});
        dq_q  <= {dq_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DEN_W-1:0];
        dq_q  <= {dq_q[ACC_W-2:0], 1'b0};
      end
    end
  end

  // Results
  logic [ACC_W-1:0] fir_res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr) begin
      fir_res_q <= '0;
    end else if (cmd_i.fir_latch) begin
      fir_res_q <= neg_q ? (ACC_W'(0) - dq_q) : dq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_avg_q <= '0;
    end else if (cmd_i.avg_latch) begin
      last_avg_q <= avg_q32[AVG_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      filtered_value_o <= fir_res_q;
      average_value_o  <= last_avg_q;
      average_valid_o  <= (seen_q != '0);
    end
  end

  assign sts_o.taps     = taps_sat;
  assign sts_o.mac_busy = v1_q | v2_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.seen_nz  = (seen_q != '0);

`ifndef SYNTHESIS
  a_wp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(wp_q))
    else $error("write pointer moved without a commit");
  a_seen_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CNT_W'(HIST_DEPTH))
    else $error("sample count above history depth");
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_fir || cmd_i.div_avg) |=> div_busy)
    else $error("divider did not start");
`endif

endmodule

[rtl/core/fir_filter_with_moving_average.sv]
// Top level: FIR filter with gain stage and moving average.
// Result register loads after a load transaction is accepted, and after a push once it is done
// (MAC steps skipped with zero taps, average divide skipped while the average is empty): one MAC per tap,
// then the gain steps and waits on the shared restoring divider. Next item taken in the cycle after that load.
// Reset (rst_ni, async low) clears history valid bits, pointer and sums, and returns config to its reset values.
// A finished result waits in the output register while the next item is taken.
module fir_filter_with_moving_average
  import fwma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [IDX_W-1:0]    coef_index_i,
  input  logic [COEF_W-1:0]   coef_value_i,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ACC_W-1:0]    filtered_value_o,
  output logic [AVG_W-1:0]    average_value_o,
  output logic                average_valid_o
);

  fwma_cmd_t cmd;
  fwma_sts_t sts;

  fwma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fwma_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .coef_index_i     (coef_index_i),
    .coef_value_i     (coef_value_i),
    .sample_value_i   (sample_value_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .filtered_value_o (filtered_value_o),
    .average_value_o  (average_value_o),
    .average_valid_o  (average_valid_o)
  );

endmodule
